### hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants of the shell style tokenizer
// Result records, the per-byte bundle passed from front to back end, quote
// modes, register indexes and the special characters of the syntax.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Result slots in one bundle; one input byte fills at most four of them.
    localparam int MAX_RESULTS = 6;
    localparam int RES_CNT_W   = 3;

    // Number of operator registers in the register map.
    localparam int NUM_OP_REGS = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_BASE  = 3'd1;

    // Depth of the queue between the front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        Q_NONE      = 2'd0,
        Q_IN_DQUOTE = 2'd1,
        Q_IN_SQUOTE = 2'd2
    } quote_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       tok_end;
        logic       is_op;
        logic       done;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic    [RES_CNT_W-1:0]   cnt;
    } bundle_t;

    typedef struct packed {
        logic hit;
        logic two;
    } match_t;

endpackage

### hdl/shell_style_tokenizer.sv
// ----------------------------------------------------------------------------
// shell_style_tokenizer: shell-like word and operator splitter
// Splits a byte stream into words, quoted text and operator tokens.
// ----------------------------------------------------------------------------
// The block takes one text byte per request and accepts a new byte every
// cycle while its four-entry bundle queue has room; when the queue is full,
// the input stalls for that cycle even if the back end frees an entry at the
// same edge. A byte may cause zero to four result requests; the output side
// sends one result per cycle while the receiver is ready, and the queue
// absorbs bursts while the average stays near one result per byte. A byte's
// first result is registered in the bundle queue and then in the output
// register before it is offered on the output. Words split at unquoted
// spaces, double and single quotes switch quote mode, and a backslash makes
// the next byte literal. Up to four operator strings of one or two bytes,
// set through the configuration port, become tokens of their own, the first
// in list order winning; an operator byte waits for the next byte to choose
// between one and two byte matches. Word bytes leave one or two bytes late,
// since a byte is known to end its word only when a later one arrives.
// After the byte marked last, the word is flushed and an end marker follows.
// Registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module shell_style_tokenizer
    import sst_pkg::*;
#(
    parameter int MAX_OPERATORS = 4,
    parameter int OPERATOR_LEN  = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port: index 0 operator count, 1 to 4 operators.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Text bytes in.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] char_in
    input  logic                  s_axis_tlast,   // final_char

    // Token bytes out.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] token_char
    output logic [2:0]            m_axis_tuser,   // [0] token_end, [1] is_operator,
                                                  // [2] text_done
    output logic                  m_axis_tlast    // run_last
);

    // Only as many operator registers are kept as can ever be checked.
    localparam int NUM_OP = (MAX_OPERATORS < NUM_OP_REGS) ? MAX_OPERATORS : NUM_OP_REGS;

    logic    accept;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_valid;
    bundle_t front_bundle;
    bundle_t q_head;

    // The input is taken whenever the queue can take another bundle.
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Front end: classifies each byte and builds its bundle of results.
    sst_front #(
        .NUM_OP (NUM_OP),
        .OP_LEN (OPERATOR_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .char_in    (s_axis_tdata),
        .final_char (s_axis_tlast),
        .bundle     (front_bundle),
        .push       (q_push)
    );

    // Bundles that carry no result are never queued.
    sst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (front_bundle),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    // Back end: sends the results of the head bundle one per cycle while the output is ready.
    sst_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (m_axis_tdata),
        .out_flags  (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

`ifndef SYNTH
    // The end marker is always the last result of its byte and carries
    // neither a character nor a token end.
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |->
            (m_axis_tlast && m_axis_tdata == 8'h00 && !m_axis_tuser[0]))
        else $error("end marker is malformed");

    // A bundle is freed only when the queue holds one.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // A full queue stops new bytes.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("bundle pushed into a full queue");
`endif

endmodule

### hdl/sst_front.sv
// ----------------------------------------------------------------------------
// sst_front: byte classifier of the shell style tokenizer
// Holds the operator registers and the quote, escape, lookahead and held
// word byte state. Each accepted byte yields one bundle of results.
// ----------------------------------------------------------------------------
module sst_front
    import sst_pkg::*;
#(
    parameter int NUM_OP  = 4,
    parameter int OP_LEN  = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [7:0]            char_in,
    input  logic                  final_char,
    output bundle_t               bundle,
    output logic                  push
);

    logic [2:0]             op_count_reg;
    logic [NUM_OP-1:0][15:0] op_reg;

    quote_t     quote_reg,      quote_next;
    logic [7:0] look_char_reg,  look_char_next;
    logic       look_valid_reg, look_valid_next;
    logic       esc_reg,        esc_next;
    logic [7:0] held_char_reg,  held_char_next;
    logic       held_valid_reg, held_valid_next;

    // First operator in list order whose bytes match wins.
    function automatic match_t op_match(logic [7:0] c, logic has_next, logic [7:0] nx,
                                        logic [2:0] count, logic [NUM_OP-1:0][15:0] ops);
        match_t     m;
        logic [7:0] lo;
        logic [7:0] hi;
        m = '0;
        for (int i = NUM_OP - 1; i >= 0; i--)
        begin
            lo = ops[i][7:0];
            hi = (OP_LEN < 2) ? 8'h00 : ops[i][15:8];
            if ((int'(count) > i) && (lo != 8'h00) && (lo == c))
            begin
                if (hi == 8'h00)
                begin
                    m.hit = 1'b1;
                    m.two = 1'b0;
                end
                else if (has_next && (nx == hi))
                begin
                    m.hit = 1'b1;
                    m.two = 1'b1;
                end
            end
        end
        return m;
    endfunction

    function automatic bundle_t put_res(bundle_t b, logic [7:0] ch, logic te, logic op,
                                        logic dn);
        bundle_t r;
        r = b;
        r.res[r.cnt] = '{ch: ch, tok_end: te, is_op: op, done: dn};
        r.cnt = r.cnt + RES_CNT_W'(1);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_count_reg <= '0;
            op_reg       <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_OP_COUNT)
            begin
                op_count_reg <= cfg_data[2:0];
            end
            for (int i = 0; i < NUM_OP; i++)
            begin
                if (cfg_index == CFG_OP_BASE + CFG_IDX_W'(i))
                begin
                    op_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        bundle_t    b;
        match_t     m;
        logic       consumed;
        quote_t     q;
        logic [7:0] lc;
        logic       lv;
        logic       esc;
        logic [7:0] hc;
        logic       hv;

        b        = '0;
        consumed = 1'b0;
        q        = quote_reg;
        lc       = look_char_reg;
        lv       = look_valid_reg;
        esc      = esc_reg;
        hc       = held_char_reg;
        hv       = held_valid_reg;

        // A waiting byte is decided by the byte that arrives now.
        m = op_match(lc, 1'b1, char_in, op_count_reg, op_reg);
        if (lv)
        begin
            lv = 1'b0;
            if (!m.hit)
            begin
                if (hv)
                begin
                    b = put_res(b, hc, 1'b0, 1'b0, 1'b0);
                end
                hc = lc;
                hv = 1'b1;
            end
            else
            begin
                if (hv)
                begin
                    b = put_res(b, hc, 1'b1, 1'b0, 1'b0);
                end
                hv = 1'b0;
                if (m.two)
                begin
                    b = put_res(b, lc, 1'b0, 1'b1, 1'b0);
                    b = put_res(b, char_in, 1'b1, 1'b1, 1'b0);
                    consumed = 1'b1;
                end
                else
                begin
                    b = put_res(b, lc, 1'b1, 1'b1, 1'b0);
                end
            end
        end

        if (!consumed)
        begin
            if (esc)
            begin
                esc = 1'b0;
                if (hv)
                begin
                    b = put_res(b, hc, 1'b0, 1'b0, 1'b0);
                end
                hc = char_in;
                hv = 1'b1;
            end
            else
            begin
                case (q)
                    Q_IN_DQUOTE, Q_IN_SQUOTE:
                    begin
                        if ((q == Q_IN_DQUOTE && char_in == CH_DQUOTE) ||
                            (q == Q_IN_SQUOTE && char_in == CH_SQUOTE))
                        begin
                            q = Q_NONE;
                        end
                        else if (char_in == CH_BSLASH)
                        begin
                            esc = 1'b1;
                        end
                        else
                        begin
                            if (hv)
                            begin
                                b = put_res(b, hc, 1'b0, 1'b0, 1'b0);
                            end
                            hc = char_in;
                            hv = 1'b1;
                        end
                    end
                    Q_NONE:
                    begin
                        if (char_in == CH_SPACE)
                        begin
                            if (hv)
                            begin
                                b = put_res(b, hc, 1'b1, 1'b0, 1'b0);
                            end
                            hv = 1'b0;
                        end
                        else if (char_in == CH_DQUOTE)
                        begin
                            q = Q_IN_DQUOTE;
                        end
                        else if (char_in == CH_SQUOTE)
                        begin
                            q = Q_IN_SQUOTE;
                        end
                        else if (char_in == CH_BSLASH)
                        begin
                            esc = 1'b1;
                        end
                        else
                        begin
                            lc = char_in;
                            lv = 1'b1;
                        end
                    end
                    default:
                    begin
                        q = Q_NONE;
                    end
                endcase
            end
        end

        // End of text: decide a waiting byte with nothing after it, flush the
        // word, send the end marker and return to the idle state.
        if (final_char)
        begin
            m = op_match(lc, 1'b0, 8'h00, op_count_reg, op_reg);
            if (lv)
            begin
                if (!m.hit)
                begin
                    if (hv)
                    begin
                        b = put_res(b, hc, 1'b0, 1'b0, 1'b0);
                    end
                    hc = lc;
                    hv = 1'b1;
                end
                else
                begin
                    if (hv)
                    begin
                        b = put_res(b, hc, 1'b1, 1'b0, 1'b0);
                    end
                    hv = 1'b0;
                    b = put_res(b, lc, 1'b1, 1'b1, 1'b0);
                end
            end
            if (hv)
            begin
                b = put_res(b, hc, 1'b1, 1'b0, 1'b0);
            end
            hv  = 1'b0;
            b   = put_res(b, 8'h00, 1'b0, 1'b0, 1'b1);
            q   = Q_NONE;
            esc = 1'b0;
            lv  = 1'b0;
        end

        bundle          = b;
        quote_next      = q;
        look_char_next  = lc;
        look_valid_next = lv;
        esc_next        = esc;
        held_char_next  = hc;
        held_valid_next = hv;
    end

    assign push = accept && (bundle.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_reg      <= Q_NONE;
            look_valid_reg <= 1'b0;
            esc_reg        <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            quote_reg      <= quote_next;
            look_valid_reg <= look_valid_next;
            esc_reg        <= esc_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            look_char_reg <= look_char_next;
            held_char_reg <= held_char_next;
        end
    end

endmodule

### hdl/sst_queue.sv
// ----------------------------------------------------------------------------
// sst_queue: bundle queue of the shell style tokenizer
// A short first-in first-out queue of result bundles between the classifier
// and the serializer.
// ----------------------------------------------------------------------------
module sst_queue
    import sst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    head_valid,
    output bundle_t head
);

    bundle_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### hdl/sst_back.sv
// ----------------------------------------------------------------------------
// sst_back: result serializer of the shell style tokenizer
// Walks through the head bundle one result per cycle, while the output is
// ready, into an output register and frees the bundle after its last result.
// ----------------------------------------------------------------------------
module sst_back
    import sst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  bundle_t    head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic [2:0] out_flags,
    output logic       out_last
);

    logic [RES_CNT_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    result_t              res_reg;
    logic                 last_reg;
    logic                 load;
    logic                 is_last;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == head.cnt - RES_CNT_W'(1));
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + RES_CNT_W'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head.res[idx_reg];
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = res_reg.ch;
    assign out_flags = {res_reg.done, res_reg.is_op, res_reg.tok_end};
    assign out_last  = last_reg;

endmodule
